// ===== rtl/spi_pkg.sv =====
// Shared constants for the segment pair intersection block.
// No dependencies; used by spi_floordiv and segment_pair_intersection.
package spi_pkg;

   // Default coordinate width: signed fixed point, Q12.4 at the default.
   localparam int COORD_BITS_DEF = 16;

endpackage

// ===== rtl/spi_floordiv.sv =====
// Pipelined restoring divider that returns floor(num / den) for the crossing point.
// Depends on spi_pkg for the default coordinate width.
module spi_floordiv #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [3*COORD_BITS+3:0] num,
   input  logic signed [2*COORD_BITS+2:0] den,
   output logic signed [COORD_BITS+1:0]  quo
);

   localparam int Q  = COORD_BITS + 1;     // quotient bits produced
   localparam int NW = 3 * COORD_BITS + 4; // numerator width
   localparam int DW = 2 * COORD_BITS + 3; // denominator width

   logic [DW-1:0] rem_ff [0:Q];
   logic [Q-1:0]  nq_ff  [0:Q];
   logic [DW-1:0] d_ff   [0:Q];
   logic          neg_ff [0:Q];

   logic [NW-1:0] absn_in;
   logic [DW-1:0] absd_in;
   logic          neg_in;

   // Take magnitudes and remember whether the true quotient is negative.
   always_comb begin
      absn_in = num[NW-1] ? NW'(-num) : NW'(num);
      absd_in = den[DW-1] ? DW'(-den) : DW'(den);
      neg_in  = num[NW-1] ^ den[DW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= absn_in[NW-1:Q];
         nq_ff[0]  <= absn_in[Q-1:0];
         d_ff[0]   <= absd_in;
         neg_ff[0] <= neg_in;
      end
   end

   // One quotient bit per stage; numerator bits shift out as quotient bits shift in.
   for (genvar k = 0; k < Q; k++) begin : g_step
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [Q-1:0]  nq_in;

      always_comb begin
         trial  = {rem_ff[k], nq_ff[k][Q-1]};
         diff   = trial - {1'b0, d_ff[k]};
         ge     = (trial >= {1'b0, d_ff[k]});
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         nq_in  = {nq_ff[k][Q-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            nq_ff[k+1]  <= nq_in;
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // Round toward minus infinity: a negative inexact quotient drops by one.
   logic signed [Q:0] tq;
   always_comb begin
      tq = $signed({1'b0, nq_ff[Q]});
      if (!neg_ff[Q]) begin
         quo = tq;
      end else if (|rem_ff[Q]) begin
         quo = ~tq;
      end else begin
         quo = -tq;
      end
   end

endmodule

// ===== rtl/segment_pair_intersection.sv =====
// Top level of the segment pair intersection block.
// Depends on spi_pkg and spi_floordiv.
//
// Takes a pair of 2D segments per word and returns one word saying whether they cross and,
// if so, the crossing point rounded toward minus infinity (zero coordinates on a miss).
// All tests are exact cross-multiplied compares. The block is a straight pipeline: a new
// word can enter every cycle unless the pipeline holds; its length is set by the
// restoring divider, which makes one quotient bit per stage. When a result waits under
// rsp_stall the whole pipeline holds, so req_stall follows rsp_stall while a result is
// presented.
module segment_pair_intersection #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_start_x,
   input  logic signed [COORD_BITS-1:0] req_a_start_y,
   input  logic signed [COORD_BITS-1:0] req_a_end_x,
   input  logic signed [COORD_BITS-1:0] req_a_end_y,
   input  logic signed [COORD_BITS-1:0] req_b_start_x,
   input  logic signed [COORD_BITS-1:0] req_b_start_y,
   input  logic signed [COORD_BITS-1:0] req_b_end_x,
   input  logic signed [COORD_BITS-1:0] req_b_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [COORD_BITS-1:0] rsp_cross_x,
   output logic signed [COORD_BITS-1:0] rsp_cross_y
);

   localparam int C  = COORD_BITS;
   localparam int W1 = C + 1;        // differences
   localparam int WP = 2 * C + 1;    // coordinate products
   localparam int WN = 2 * C + 2;    // rational numerators
   localparam int WD = 2 * C + 3;    // determinant and tn
   localparam int WX = 3 * C + 3;    // cross-multiplied compares
   localparam int NW = 3 * C + 4;    // divider numerator
   localparam int L  = C + 2;        // length of the delay line beside the dividers

   logic en;
   logic rsp_vld_ff;

   // The whole pipeline advances unless a presented result is held.
   assign en        = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------- Stage 1: order each segment by x ----------------
   logic s1_vld_ff;
   logic signed [C-1:0] s1_ax0_ff, s1_ay0_ff, s1_ax1_ff, s1_ay1_ff;
   logic signed [C-1:0] s1_bx0_ff, s1_by0_ff, s1_bx1_ff, s1_by1_ff;
   logic signed [C-1:0] s1_ax0_in, s1_ay0_in, s1_ax1_in, s1_ay1_in;
   logic signed [C-1:0] s1_bx0_in, s1_by0_in, s1_bx1_in, s1_by1_in;

   always_comb begin
      if (req_a_end_x < req_a_start_x) begin
         s1_ax0_in = req_a_end_x;   s1_ay0_in = req_a_end_y;
         s1_ax1_in = req_a_start_x; s1_ay1_in = req_a_start_y;
      end else begin
         s1_ax0_in = req_a_start_x; s1_ay0_in = req_a_start_y;
         s1_ax1_in = req_a_end_x;   s1_ay1_in = req_a_end_y;
      end
      if (req_b_end_x < req_b_start_x) begin
         s1_bx0_in = req_b_end_x;   s1_by0_in = req_b_end_y;
         s1_bx1_in = req_b_start_x; s1_by1_in = req_b_start_y;
      end else begin
         s1_bx0_in = req_b_start_x; s1_by0_in = req_b_start_y;
         s1_bx1_in = req_b_end_x;   s1_by1_in = req_b_end_y;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ax0_ff <= s1_ax0_in; s1_ay0_ff <= s1_ay0_in;
         s1_ax1_ff <= s1_ax1_in; s1_ay1_ff <= s1_ay1_in;
         s1_bx0_ff <= s1_bx0_in; s1_by0_ff <= s1_by0_in;
         s1_bx1_ff <= s1_bx1_in; s1_by1_ff <= s1_by1_in;
      end
   end

   // ---------------- Stage 2: spans, windows and deltas ----------------
   logic s2_vld_ff;
   logic signed [C-1:0]  s2_ax0_ff, s2_ay0_ff, s2_bx0_ff, s2_by0_ff;
   logic signed [C-1:0]  s2_lox_ff, s2_hix_ff, s2_loy_ff, s2_hiy_ff;
   logic signed [W1-1:0] s2_dxa_ff, s2_dya_ff, s2_dxb_ff, s2_dyb_ff;
   logic signed [W1-1:0] s2_oxab_ff, s2_oyab_ff;
   logic                 s2_av_ff, s2_bv_ff;
   logic signed [C-1:0]  s2_lox_in, s2_hix_in, s2_loy_in, s2_hiy_in;
   logic signed [C-1:0]  amin, amax, bmin, bmax;
   logic signed [W1-1:0] s2_dxa_in, s2_dya_in, s2_dxb_in, s2_dyb_in;
   logic signed [W1-1:0] s2_oxab_in, s2_oyab_in;
   logic                 s2_av_in, s2_bv_in;

   always_comb begin
      s2_lox_in  = (s1_ax0_ff > s1_bx0_ff) ? s1_ax0_ff : s1_bx0_ff;
      s2_hix_in  = (s1_ax1_ff < s1_bx1_ff) ? s1_ax1_ff : s1_bx1_ff;
      amin       = (s1_ay0_ff < s1_ay1_ff) ? s1_ay0_ff : s1_ay1_ff;
      amax       = (s1_ay0_ff > s1_ay1_ff) ? s1_ay0_ff : s1_ay1_ff;
      bmin       = (s1_by0_ff < s1_by1_ff) ? s1_by0_ff : s1_by1_ff;
      bmax       = (s1_by0_ff > s1_by1_ff) ? s1_by0_ff : s1_by1_ff;
      s2_loy_in  = (amin > bmin) ? amin : bmin;
      s2_hiy_in  = (amax < bmax) ? amax : bmax;
      s2_dxa_in  = W1'(s1_ax1_ff) - W1'(s1_ax0_ff);
      s2_dya_in  = W1'(s1_ay1_ff) - W1'(s1_ay0_ff);
      s2_dxb_in  = W1'(s1_bx1_ff) - W1'(s1_bx0_ff);
      s2_dyb_in  = W1'(s1_by1_ff) - W1'(s1_by0_ff);
      s2_oxab_in = W1'(s1_bx0_ff) - W1'(s1_ax0_ff);
      s2_oyab_in = W1'(s1_by0_ff) - W1'(s1_ay0_ff);
      s2_av_in   = (s1_ax1_ff == s1_ax0_ff);
      s2_bv_in   = (s1_bx1_ff == s1_bx0_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ax0_ff  <= s1_ax0_ff; s2_ay0_ff <= s1_ay0_ff;
         s2_bx0_ff  <= s1_bx0_ff; s2_by0_ff <= s1_by0_ff;
         s2_lox_ff  <= s2_lox_in; s2_hix_ff <= s2_hix_in;
         s2_loy_ff  <= s2_loy_in; s2_hiy_ff <= s2_hiy_in;
         s2_dxa_ff  <= s2_dxa_in; s2_dya_ff <= s2_dya_in;
         s2_dxb_ff  <= s2_dxb_in; s2_dyb_ff <= s2_dyb_in;
         s2_oxab_ff <= s2_oxab_in; s2_oyab_ff <= s2_oyab_in;
         s2_av_ff   <= s2_av_in;  s2_bv_ff  <= s2_bv_in;
      end
   end

   // ---------------- Stage 3: offsets to the bounds, denominators ----------------
   logic s3_vld_ff;
   logic signed [C-1:0]  s3_ax0_ff, s3_ay0_ff, s3_by0_ff, s3_lox_ff, s3_loy_ff, s3_hiy_ff;
   logic signed [W1-1:0] s3_dxa_ff, s3_dya_ff, s3_dxb_ff, s3_dyb_ff, s3_oxab_ff, s3_oyab_ff;
   logic signed [W1-1:0] s3_la_ff, s3_ha_ff, s3_lb_ff, s3_hb_ff, s3_da_ff, s3_db_ff;
   logic                 s3_av_ff, s3_bv_ff, s3_empty_ff;
   logic signed [W1-1:0] s3_la_in, s3_ha_in, s3_lb_in, s3_hb_in, s3_da_in, s3_db_in;
   logic                 s3_empty_in;

   always_comb begin
      s3_la_in    = W1'(s2_lox_ff) - W1'(s2_ax0_ff);
      s3_ha_in    = W1'(s2_hix_ff) - W1'(s2_ax0_ff);
      s3_lb_in    = W1'(s2_lox_ff) - W1'(s2_bx0_ff);
      s3_hb_in    = W1'(s2_hix_ff) - W1'(s2_bx0_ff);
      s3_da_in    = s2_av_ff ? W1'(1) : s2_dxa_ff;
      s3_db_in    = s2_bv_ff ? W1'(1) : s2_dxb_ff;
      s3_empty_in = (s2_hix_ff < s2_lox_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ax0_ff  <= s2_ax0_ff;  s3_ay0_ff  <= s2_ay0_ff;  s3_by0_ff <= s2_by0_ff;
         s3_lox_ff  <= s2_lox_ff;  s3_loy_ff  <= s2_loy_ff;  s3_hiy_ff <= s2_hiy_ff;
         s3_dxa_ff  <= s2_dxa_ff;  s3_dya_ff  <= s2_dya_ff;
         s3_dxb_ff  <= s2_dxb_ff;  s3_dyb_ff  <= s2_dyb_ff;
         s3_oxab_ff <= s2_oxab_ff; s3_oyab_ff <= s2_oyab_ff;
         s3_la_ff   <= s3_la_in;   s3_ha_ff   <= s3_ha_in;
         s3_lb_ff   <= s3_lb_in;   s3_hb_ff   <= s3_hb_in;
         s3_da_ff   <= s3_da_in;   s3_db_ff   <= s3_db_in;
         s3_av_ff   <= s2_av_ff;   s3_bv_ff   <= s2_bv_ff;
         s3_empty_ff <= s3_empty_in;
      end
   end

   // ---------------- Stage 4: products ----------------
   logic s4_vld_ff;
   logic signed [WP-1:0] s4_pay_ff, s4_pal_ff, s4_pah_ff, s4_pby_ff, s4_pbl_ff, s4_pbh_ff;
   logic signed [WP-1:0] s4_fa_ff, s4_ca_ff, s4_fb_ff, s4_cb_ff;
   logic signed [WP-1:0] s4_den1_ff, s4_den2_ff, s4_tn1_ff, s4_tn2_ff;
   logic signed [C-1:0]  s4_ax0_ff, s4_ay0_ff, s4_by0_ff, s4_lox_ff, s4_loy_ff, s4_hiy_ff;
   logic signed [W1-1:0] s4_dxa_ff, s4_dya_ff, s4_dxb_ff, s4_dyb_ff, s4_oxab_ff;
   logic signed [W1-1:0] s4_la_ff, s4_da_ff, s4_db_ff;
   logic                 s4_av_ff, s4_bv_ff, s4_empty_ff;
   logic signed [WP-1:0] s4_pay_in, s4_pal_in, s4_pah_in, s4_pby_in, s4_pbl_in, s4_pbh_in;
   logic signed [WP-1:0] s4_fa_in, s4_ca_in, s4_fb_in, s4_cb_in;
   logic signed [WP-1:0] s4_den1_in, s4_den2_in, s4_tn1_in, s4_tn2_in;

   always_comb begin
      s4_pay_in  = WP'(s3_ay0_ff) * WP'(s3_dxa_ff);
      s4_pal_in  = WP'(s3_dya_ff) * WP'(s3_la_ff);
      s4_pah_in  = WP'(s3_dya_ff) * WP'(s3_ha_ff);
      s4_pby_in  = WP'(s3_by0_ff) * WP'(s3_dxb_ff);
      s4_pbl_in  = WP'(s3_dyb_ff) * WP'(s3_lb_ff);
      s4_pbh_in  = WP'(s3_dyb_ff) * WP'(s3_hb_ff);
      s4_fa_in   = WP'(s3_loy_ff) * WP'(s3_da_ff);
      s4_ca_in   = WP'(s3_hiy_ff) * WP'(s3_da_ff);
      s4_fb_in   = WP'(s3_loy_ff) * WP'(s3_db_ff);
      s4_cb_in   = WP'(s3_hiy_ff) * WP'(s3_db_ff);
      s4_den1_in = WP'(s3_dxa_ff) * WP'(s3_dyb_ff);
      s4_den2_in = WP'(s3_dya_ff) * WP'(s3_dxb_ff);
      s4_tn1_in  = WP'(s3_oxab_ff) * WP'(s3_dyb_ff);
      s4_tn2_in  = WP'(s3_oyab_ff) * WP'(s3_dxb_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_pay_ff  <= s4_pay_in;  s4_pal_ff <= s4_pal_in; s4_pah_ff <= s4_pah_in;
         s4_pby_ff  <= s4_pby_in;  s4_pbl_ff <= s4_pbl_in; s4_pbh_ff <= s4_pbh_in;
         s4_fa_ff   <= s4_fa_in;   s4_ca_ff  <= s4_ca_in;
         s4_fb_ff   <= s4_fb_in;   s4_cb_ff  <= s4_cb_in;
         s4_den1_ff <= s4_den1_in; s4_den2_ff <= s4_den2_in;
         s4_tn1_ff  <= s4_tn1_in;  s4_tn2_ff  <= s4_tn2_in;
         s4_ax0_ff  <= s3_ax0_ff;  s4_ay0_ff  <= s3_ay0_ff; s4_by0_ff <= s3_by0_ff;
         s4_lox_ff  <= s3_lox_ff;  s4_loy_ff  <= s3_loy_ff; s4_hiy_ff <= s3_hiy_ff;
         s4_dxa_ff  <= s3_dxa_ff;  s4_dya_ff  <= s3_dya_ff;
         s4_dxb_ff  <= s3_dxb_ff;  s4_dyb_ff  <= s3_dyb_ff; s4_oxab_ff <= s3_oxab_ff;
         s4_la_ff   <= s3_la_ff;   s4_da_ff   <= s3_da_ff;  s4_db_ff <= s3_db_ff;
         s4_av_ff   <= s3_av_ff;   s4_bv_ff   <= s3_bv_ff;  s4_empty_ff <= s3_empty_ff;
      end
   end

   // ---------------- Stage 5: numerators at the bounds, determinant ----------------
   logic s5_vld_ff;
   logic signed [WN-1:0] s5_na0_ff, s5_na1_ff, s5_nb0_ff, s5_nb1_ff;
   logic signed [WP-1:0] s5_fa_ff, s5_ca_ff, s5_fb_ff, s5_cb_ff;
   logic signed [WD-1:0] s5_den_ff, s5_tn_ff;
   logic signed [C-1:0]  s5_ax0_ff, s5_ay0_ff, s5_by0_ff, s5_lox_ff, s5_loy_ff;
   logic signed [W1-1:0] s5_dxa_ff, s5_dya_ff, s5_dxb_ff, s5_dyb_ff, s5_oxab_ff;
   logic signed [W1-1:0] s5_la_ff, s5_da_ff, s5_db_ff;
   logic                 s5_av_ff, s5_bv_ff, s5_empty_ff;
   logic signed [WN-1:0] s5_na0_in, s5_na1_in, s5_nb0_in, s5_nb1_in;
   logic signed [WD-1:0] s5_den_in, s5_tn_in;

   // A vertical segment reads as the window floor on the left and ceiling on the right.
   always_comb begin
      s5_na0_in = s4_av_ff ? WN'(s4_loy_ff) : WN'(s4_pay_ff) + WN'(s4_pal_ff);
      s5_na1_in = s4_av_ff ? WN'(s4_hiy_ff) : WN'(s4_pay_ff) + WN'(s4_pah_ff);
      s5_nb0_in = s4_bv_ff ? WN'(s4_loy_ff) : WN'(s4_pby_ff) + WN'(s4_pbl_ff);
      s5_nb1_in = s4_bv_ff ? WN'(s4_hiy_ff) : WN'(s4_pby_ff) + WN'(s4_pbh_ff);
      s5_den_in = WD'(s4_den1_ff) - WD'(s4_den2_ff);
      s5_tn_in  = WD'(s4_tn1_ff) - WD'(s4_tn2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_na0_ff  <= s5_na0_in; s5_na1_ff <= s5_na1_in;
         s5_nb0_ff  <= s5_nb0_in; s5_nb1_ff <= s5_nb1_in;
         s5_fa_ff   <= s4_fa_ff;  s5_ca_ff  <= s4_ca_ff;
         s5_fb_ff   <= s4_fb_ff;  s5_cb_ff  <= s4_cb_ff;
         s5_den_ff  <= s5_den_in; s5_tn_ff  <= s5_tn_in;
         s5_ax0_ff  <= s4_ax0_ff; s5_ay0_ff <= s4_ay0_ff; s5_by0_ff <= s4_by0_ff;
         s5_lox_ff  <= s4_lox_ff; s5_loy_ff <= s4_loy_ff;
         s5_dxa_ff  <= s4_dxa_ff; s5_dya_ff <= s4_dya_ff;
         s5_dxb_ff  <= s4_dxb_ff; s5_dyb_ff <= s4_dyb_ff; s5_oxab_ff <= s4_oxab_ff;
         s5_la_ff   <= s4_la_ff;  s5_da_ff  <= s4_da_ff;  s5_db_ff <= s4_db_ff;
         s5_av_ff   <= s4_av_ff;  s5_bv_ff  <= s4_bv_ff;  s5_empty_ff <= s4_empty_ff;
      end
   end

   // ---------------- Stage 6: window test, order products, divider operands ----------------
   logic s6_vld_ff;
   logic                 s6_miss_ff;
   logic signed [WX-1:0] s6_l0_ff, s6_r0_ff, s6_l1_ff, s6_r1_ff;
   logic signed [NW-1:0] s6_numx_ff, s6_numy_ff;
   logic signed [WD-1:0] s6_dvx_ff, s6_dvy_ff;
   logic signed [C-1:0]  s6_bsx_ff, s6_bsy_ff;
   logic                 s6_miss_in;
   logic signed [WX-1:0] s6_l0_in, s6_r0_in, s6_l1_in, s6_r1_in;
   logic signed [NW-1:0] s6_numx_in, s6_numy_in;
   logic signed [WD-1:0] s6_dvx_in, s6_dvy_in;
   logic signed [C-1:0]  s6_bsx_in, s6_bsy_in;
   logic signed [W1-1:0] ymul_a;
   logic signed [WD-1:0] ymul_b;
   logic                 den0;

   always_comb begin
      // Miss when the x windows do not overlap or either segment stays wholly below the floor or above the ceiling.
      s6_miss_in = s5_empty_ff
         || (WN'(s5_na0_ff) < WN'(s5_fa_ff) && WN'(s5_na1_ff) < WN'(s5_fa_ff))
         || (WN'(s5_nb0_ff) < WN'(s5_fb_ff) && WN'(s5_nb1_ff) < WN'(s5_fb_ff))
         || (WN'(s5_na0_ff) > WN'(s5_ca_ff) && WN'(s5_na1_ff) > WN'(s5_ca_ff))
         || (WN'(s5_nb0_ff) > WN'(s5_cb_ff) && WN'(s5_nb1_ff) > WN'(s5_cb_ff));
      s6_l0_in = WX'(s5_na0_ff) * WX'(s5_db_ff);
      s6_r0_in = WX'(s5_nb0_ff) * WX'(s5_da_ff);
      s6_l1_in = WX'(s5_na1_ff) * WX'(s5_db_ff);
      s6_r1_in = WX'(s5_nb1_ff) * WX'(s5_da_ff);

      den0 = (s5_den_ff == '0);

      // Crossing x: general case by the line formula, otherwise an exact coordinate.
      if (s5_av_ff || s5_bv_ff || den0) begin
         s6_numx_in = '0;
         s6_dvx_in  = WD'(1);
      end else begin
         s6_numx_in = NW'(s5_dxa_ff) * NW'(s5_tn_ff);
         s6_dvx_in  = s5_den_ff;
      end
      if (s5_av_ff) begin
         s6_bsx_in = s5_ax0_ff;
      end else if (s5_bv_ff) begin
         s6_bsx_in = C'(s5_ax0_ff + s5_oxab_ff[C-1:0]);
      end else if (den0) begin
         s6_bsx_in = s5_lox_ff;
      end else begin
         s6_bsx_in = s5_ax0_ff;
      end

      // Crossing y: one multiplier whose operands depend on the special case.
      if (s5_av_ff) begin
         ymul_a    = s5_dyb_ff;
         ymul_b    = -WD'(s5_oxab_ff);
         s6_dvy_in = WD'(s5_dxb_ff);
         s6_bsy_in = s5_by0_ff;
      end else if (s5_bv_ff) begin
         ymul_a    = s5_dya_ff;
         ymul_b    = WD'(s5_oxab_ff);
         s6_dvy_in = WD'(s5_dxa_ff);
         s6_bsy_in = s5_ay0_ff;
      end else if (den0) begin
         ymul_a    = s5_dya_ff;
         ymul_b    = WD'(s5_la_ff);
         s6_dvy_in = WD'(s5_dxa_ff);
         s6_bsy_in = s5_ay0_ff;
      end else begin
         ymul_a    = s5_dya_ff;
         ymul_b    = s5_tn_ff;
         s6_dvy_in = s5_den_ff;
         s6_bsy_in = s5_ay0_ff;
      end
      s6_numy_in = NW'(ymul_a) * NW'(ymul_b);
      // Both vertical: the window floor.
      if (s5_av_ff && s5_bv_ff) begin
         s6_numy_in = '0;
         s6_dvy_in  = WD'(1);
         s6_bsy_in  = s5_loy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_miss_ff <= s6_miss_in;
         s6_l0_ff   <= s6_l0_in; s6_r0_ff <= s6_r0_in;
         s6_l1_ff   <= s6_l1_in; s6_r1_ff <= s6_r1_in;
         s6_numx_ff <= s6_numx_in; s6_numy_ff <= s6_numy_in;
         s6_dvx_ff  <= s6_dvx_in;  s6_dvy_ff  <= s6_dvy_in;
         s6_bsx_ff  <= s6_bsx_in;  s6_bsy_ff  <= s6_bsy_in;
      end
   end

   // ---------------- Hit decision and dividers ----------------
   logic hit_in;
   assign hit_in = !s6_miss_ff
      && ((s6_l0_ff <= s6_r0_ff && s6_l1_ff >= s6_r1_ff)
       || (s6_l0_ff >= s6_r0_ff && s6_l1_ff <= s6_r1_ff));

   logic signed [C+1:0] quo_x, quo_y;

   spi_floordiv #(.COORD_BITS(C)) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (s6_numx_ff),
      .den   (s6_dvx_ff),
      .quo   (quo_x)
   );

   spi_floordiv #(.COORD_BITS(C)) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (s6_numy_ff),
      .den   (s6_dvy_ff),
      .quo   (quo_y)
   );

   // Hit flag and bases ride alongside the dividers.
   logic                dly_vld_ff [0:L-1];
   logic                dly_hit_ff [0:L-1];
   logic signed [C-1:0] dly_bsx_ff [0:L-1];
   logic signed [C-1:0] dly_bsy_ff [0:L-1];

   always_ff @(posedge clock) begin
      if (en) begin
         dly_hit_ff[0] <= hit_in;
         dly_bsx_ff[0] <= s6_bsx_ff;
         dly_bsy_ff[0] <= s6_bsy_ff;
         for (int k = 1; k < L; k++) begin
            dly_hit_ff[k] <= dly_hit_ff[k-1];
            dly_bsx_ff[k] <= dly_bsx_ff[k-1];
            dly_bsy_ff[k] <= dly_bsy_ff[k-1];
         end
      end
   end

   // Valid bits for every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0; s2_vld_ff <= 1'b0; s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0; s5_vld_ff <= 1'b0; s6_vld_ff <= 1'b0;
         for (int k = 0; k < L; k++) begin
            dly_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         s1_vld_ff <= req_valid; s2_vld_ff <= s1_vld_ff; s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff; s5_vld_ff <= s4_vld_ff; s6_vld_ff <= s5_vld_ff;
         dly_vld_ff[0] <= s6_vld_ff;
         for (int k = 1; k < L; k++) begin
            dly_vld_ff[k] <= dly_vld_ff[k-1];
         end
      end
   end

   // ---------------- Output register ----------------
   logic                rsp_hit_ff;
   logic signed [C-1:0] rsp_x_ff, rsp_y_ff;
   logic signed [C+1:0] sum_x, sum_y;
   logic signed [C-1:0] rsp_x_in, rsp_y_in;

   always_comb begin
      sum_x    = (C+2)'(dly_bsx_ff[L-1]) + quo_x;
      sum_y    = (C+2)'(dly_bsy_ff[L-1]) + quo_y;
      rsp_x_in = dly_hit_ff[L-1] ? sum_x[C-1:0] : '0;
      rsp_y_in = dly_hit_ff[L-1] ? sum_y[C-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dly_vld_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= dly_hit_ff[L-1];
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_cross_x = rsp_x_ff;
   assign rsp_cross_y = rsp_y_ff;

endmodule
